[rtl/trle_pkg.sv]
// ----------------------------------------------------------------------------
// trle_pkg
// Types and constants shared by the truecolor run-length pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PIX_PER_ROW      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_BYTE_PIXELS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RUN_LENGTH_CODED = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TOP_ORIGIN       = 3'd4;

  localparam logic [7:0] PACKET_REPEAT_BIT = 8'h80;
  localparam logic [7:0] PACKET_COUNT_MASK = 8'h7f;

  typedef struct packed {
    logic [15:0] pix_per_row;
    logic [15:0] num_rows;
    logic        four_byte_pixels;
    logic        run_length_coded;
    logic        top_origin;
  } trle_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } trle_in_t;

  // one assembled pixel handed from the front to the back
  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [7:0]  npix;
    logic        packet_done;
  } trle_pix_t;

  typedef struct packed {
    logic [15:0] out_row;
    logic [15:0] out_column;
    logic [7:0]  run_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        image_done;
  } trle_out_t;

endpackage

[rtl/trle_stream_if.sv]
// ----------------------------------------------------------------------------
// trle_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface trle_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/trle_front.sv]
// ----------------------------------------------------------------------------
// trle_front
// Byte front end: parses packet bytes, assembles BGR(A) pixels and pushes
// one entry per completed pixel toward the run stage.
// ----------------------------------------------------------------------------
module trle_front
  import trle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trle_cfg_t cfg_i,
  trle_stream_if.sink   byte_in,
  trle_stream_if.source pix_out
);

  logic [7:0]  pkt_rem_q, pkt_rem_d;
  logic        pkt_rep_q, pkt_rep_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] pixel_q, pixel_d;

  logic       active;
  logic       is_header;
  logic       last_byte;
  logic [7:0] npix;
  logic [7:0] rem_after;
  logic [7:0] b;

  assign b         = byte_in.payload.data_byte;
  assign active    = (cfg_i.pix_per_row != '0) && (cfg_i.num_rows != '0);
  assign is_header = cfg_i.run_length_coded && (pkt_rem_q == '0);
  assign last_byte = (cfg_i.four_byte_pixels) ? (bip_q == 2'd3) : (bip_q >= 2'd2);
  assign npix      = (cfg_i.run_length_coded && pkt_rep_q) ? pkt_rem_q : 8'd1;
  assign rem_after = pkt_rem_q - npix;

  // lane write of the incoming byte into the pixel word
  always_comb begin
    pixel_d = pixel_q;
    pixel_d[{bip_q, 3'b000} +: 8] = b;
  end

  assign byte_in.ready = pix_out.ready;

  assign pix_out.valid               = byte_in.valid && active && !is_header && last_byte;
  assign pix_out.payload.pixel_bytes = pixel_d;
  assign pix_out.payload.npix        = npix;
  assign pix_out.payload.packet_done = cfg_i.run_length_coded ? (rem_after == '0) : 1'b1;

  always_comb begin
    pkt_rem_d = pkt_rem_q;
    pkt_rep_d = pkt_rep_q;
    bip_d     = bip_q;
    if (byte_in.valid && byte_in.ready && active) begin
      if (is_header) begin
        pkt_rep_d = (b & PACKET_REPEAT_BIT) != '0;
        pkt_rem_d = (b & PACKET_COUNT_MASK) + 8'd1;
        bip_d     = '0;
      end else if (!last_byte) begin
        bip_d = bip_q + 2'd1;
      end else begin
        bip_d = '0;
        if (cfg_i.run_length_coded) begin
          pkt_rem_d = rem_after;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_rem_q <= '0;
      pkt_rep_q <= 1'b0;
      bip_q     <= '0;
    end else begin
      pkt_rem_q <= pkt_rem_d;
      pkt_rep_q <= pkt_rep_d;
      bip_q     <= bip_d;
    end
  end

  // pixel word has no reset, every lane is written before use
  always_ff @(posedge clk_i) begin
    if (byte_in.valid && byte_in.ready && active && !is_header) begin
      pixel_q <= pixel_d;
    end
  end

endmodule

[rtl/trle_fifo.sv]
// ----------------------------------------------------------------------------
// trle_fifo
// Small first-in first-out queue between the byte front end and the run stage.
// ----------------------------------------------------------------------------
module trle_fifo
  import trle_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  trle_stream_if.sink   push,
  trle_stream_if.source pop,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth+1);

  trle_pix_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign push.ready  = count_q != CntW'(Depth);
  assign pop.valid   = count_q != '0;
  assign pop.payload = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  assign do_push = push.valid && push.ready;
  assign do_pop  = pop.valid && pop.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push.payload;
    end
  end

endmodule

[rtl/trle_back.sv]
// ----------------------------------------------------------------------------
// trle_back
// Run stage: places each pixel entry on the row/column grid, clips it at the
// row end, flips rows for a bottom origin and drives the registered result.
// ----------------------------------------------------------------------------
module trle_back
  import trle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trle_cfg_t cfg_i,
  trle_stream_if.sink   pix_in,
  trle_stream_if.source run_out,
  output logic      finished_o
);

  logic [15:0] row_q, row_d;
  logic [16:0] col_q, col_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  trle_out_t   out_q, out_d;

  logic        take;
  logic [16:0] width17, npix17, avail, col_sum;
  logic [7:0]  cnt;
  logic        col_end, row_last, done;
  trle_pix_t   item;

  assign item    = pix_in.payload;
  assign take    = pix_in.valid && (!out_valid_q || run_out.ready);
  assign pix_in.ready = !out_valid_q || run_out.ready;

  assign width17  = {1'b0, cfg_i.pix_per_row};
  assign npix17   = {9'b0, item.npix};
  assign avail    = (col_q < width17) ? width17 - col_q : '0;
  assign cnt      = (npix17 < avail) ? item.npix : avail[7:0];
  assign col_sum  = col_q + npix17;
  assign col_end  = col_sum >= width17;
  assign row_last = ({1'b0, row_q} + 17'd1) >= {1'b0, cfg_i.num_rows};
  assign done     = (cnt != '0) && col_end && row_last;

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      out_valid_d = !fin_q && (cnt != '0);
      out_d.out_row    = cfg_i.top_origin ? row_q : cfg_i.num_rows - 16'd1 - row_q;
      out_d.out_column = col_q[15:0];
      out_d.run_count  = cnt;
      out_d.red        = item.pixel_bytes[23:16];
      out_d.green      = item.pixel_bytes[15:8];
      out_d.blue       = item.pixel_bytes[7:0];
      out_d.alpha      = cfg_i.four_byte_pixels ? item.pixel_bytes[31:24] : '0;
      out_d.image_done = done;
      if (!fin_q) begin
        col_d = col_sum;
        if (done) begin
          fin_d = 1'b1;
        end else if (item.packet_done && col_end) begin
          // row ends, next row starts fresh
          fin_d = row_last;
          col_d = '0;
          row_d = row_q + 16'd1;
        end
      end
    end else if (run_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign run_out.valid   = out_valid_q;
  assign run_out.payload = out_q;
  assign finished_o      = fin_q;

endmodule

[rtl/tga_truecolor_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_truecolor_rle_pixel_decoder
// Decodes truecolor pixel data bytes, raw or run-length coded, into runs.
// ----------------------------------------------------------------------------
// Usage:
// - byte_in carries one image data byte per transfer, starting right after
//   the header. run_out carries one run per transfer: row, first column,
//   count, RGBA and a flag on the last run of the image.
// - Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
//   decoder is idle; writes take effect on the next cycle.
// - Throughput is one byte per cycle while byte_in.ready is high. The byte
//   front end feeds a small queue and the run stage pops one entry per cycle
//   into the output register while run_out is not stalled.
// - Packet bytes and the leading bytes of a pixel give no result; pixels
//   that land past the row end are dropped.
// - When run_out stalls, the output register holds and the queue absorbs
//   pixels until full, then byte_in.ready drops.
// - Reset clears all counters and the configuration; after the last run of
//   the image every byte is taken and ignored until the next reset.
// ----------------------------------------------------------------------------
module tga_truecolor_rle_pixel_decoder
  import trle_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  trle_stream_if.sink         byte_in,
  trle_stream_if.source       run_out
);

  trle_cfg_t cfg_q;
  logic      finished;
  logic [$clog2(FifoDepth+1)-1:0] fifo_count;

  trle_stream_if #(.payload_t(trle_pix_t)) pix_push ();
  trle_stream_if #(.payload_t(trle_pix_t)) pix_pop ();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIX_PER_ROW:      cfg_q.pix_per_row      <= cfg_data_i;
        CFG_NUM_ROWS:         cfg_q.num_rows         <= cfg_data_i;
        CFG_FOUR_BYTE_PIXELS: cfg_q.four_byte_pixels <= cfg_data_i[0];
        CFG_RUN_LENGTH_CODED: cfg_q.run_length_coded <= cfg_data_i[0];
        CFG_TOP_ORIGIN:       cfg_q.top_origin       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  trle_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .byte_in (byte_in),
    .pix_out (pix_push)
  );

  trle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (pix_push),
    .pop     (pix_pop),
    .count_o (fifo_count)
  );

  trle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_in     (pix_pop),
    .run_out    (run_out),
    .finished_o (finished)
  );

  // once the image is complete it stays complete until reset
  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished |=> finished)
    else $error("finished flag dropped without reset");

  // a delivered last run must leave the decoder finished
  a_done_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_out.valid && run_out.payload.image_done) |-> finished)
    else $error("image_done shown while not finished");

  // every run shown covers at least one pixel
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_out.valid |-> (run_out.payload.run_count != '0))
    else $error("run with zero count");

  // queue occupancy moves by at most one per cycle
  a_fifo_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_count == $past(fifo_count)) || (fifo_count == $past(fifo_count) + 1'b1)
    || (fifo_count == $past(fifo_count) - 1'b1))
    else $error("queue count jumped");

endmodule
